// ----- rtl/core/okcn_pkg.sv -----
// ============================================================================
// okcn_pkg: shared types, constants and tables of the contrast nudge
// Fixed-point widths, color matrices, the sRGB decode table and the
// sRGB encode thresholds, all worked out at elaboration.
// ============================================================================
package okcn_pkg;

    localparam int CFG_W    = 17;            // squared distance register, Q16
    localparam int LIN_W    = 17;            // unsigned 0..1.0 in Q16
    localparam int LAB_W    = 20;            // signed Oklab component, Q16
    localparam int CR_BITS  = 17;            // cube root result bits
    localparam int LAB_LAT  = CR_BITS + 5;   // stages from transfer to Lab
    localparam int SQ_BITS  = 17;            // square root result bits
    localparam int ENC_BITS = 8;             // encoded channel bits
    localparam int ONE16    = 65536;
    localparam longint ONE30 = 64'sd1 <<< 30;

    localparam int M_LMS  [9] = '{27015, 35149, 3372, 13887, 44610, 7038,
                                  5787, 18463, 41286};
    localparam int M_LAB  [9] = '{13792, 52011, -267, 129630, -159160, 29530,
                                  1698, 51300, -52997};
    localparam int M_BACK [9] = '{65536, 25974, 14143, 65536, -6918, -4185,
                                  65536, -5864, -84639};
    localparam int M_RGB  [9] = '{267173, -216774, 15137, -83128, 171033,
                                  -22369, -275, -46099, 111910};

    typedef logic [LIN_W-1:0] lut_t [256];

    typedef struct packed {
        logic signed [LAB_W-1:0] l;
        logic signed [LAB_W-1:0] a;
        logic signed [LAB_W-1:0] b;
    } lab_t;

    // truncating Q30 power
    function automatic longint pow30(longint r, int n);
        longint acc;
        acc = ONE30;
        for (int k = 0; k < n; k++)
        begin
            acc = (acc * r) >>> 30;
        end
        return acc;
    endfunction

    // largest r in 0..1.0 (Q30) whose Q30 n-th power stays at or below x
    function automatic longint root30(longint x, int n);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = ONE30;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            if (pow30(mid, n) <= x)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // sRGB byte to linear Q16
    function automatic lut_t gen_decode();
        lut_t   tab;
        longint t;
        longint t2;
        longint r;
        longint v;
        for (int i = 0; i < 256; i++)
        begin
            if (i <= 10)
                v = (longint'(i) * 6553600 + 164730) / 329460;
            else
            begin
                t  = ((longint'(i) * 1000 + 14025) <<< 30) / 269025;
                t2 = pow30(t, 2);
                r  = root30(t2, 5);
                v  = (((t2 * r) >>> 30) + 8192) >>> 14;
            end
            tab[i] = LIN_W'(v);
        end
        return tab;
    endfunction

    // smallest linear Q16 value that encodes to at least k; all ones if never
    function automatic lut_t gen_enc_thr();
        lut_t   tab;
        longint n0;
        longint ymin;
        longint lo;
        longint hi;
        longint mid;
        longint thr;
        tab[0] = '0;
        for (int k = 1; k < 256; k++)
        begin
            if (k <= 10)
                thr = (longint'(k) * 6553600 - 3276800 + 329459) / 329460;
            else
            begin
                n0   = ((longint'(k) * 1000 - 500) <<< 30);
                n0   = (n0 + 254) / 255;
                ymin = (n0 + 55 * ONE30 + 1054) / 1055;
                lo   = 0;
                hi   = ONE30 + 1;
                while (lo < hi)
                begin
                    mid = (lo + hi) / 2;
                    if (pow30(mid, 5) >= ymin)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                if (lo > ONE30)
                    thr = 64'sd131071;
                else
                begin
                    thr = (pow30(lo, 12) + 16383) >>> 14;
                    if (thr < 206)
                        thr = 206;
                end
            end
            if (thr > ONE16)
                thr = 64'sd131071;
            tab[k] = LIN_W'(thr);
        end
        return tab;
    endfunction

    localparam lut_t DEC_LUT = gen_decode();
    localparam lut_t ENC_THR = gen_enc_thr();

endpackage

// ----- rtl/core/okcn_to_lab.sv -----
// ============================================================================
// okcn_to_lab: sRGB color to Oklab
// Table decode, LMS matrix, bit-serial cube roots (one bit per stage), Lab
// matrix. Payload pipeline only; valid bits live in the top level.
// ============================================================================
module okcn_to_lab
    import okcn_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [23:0] color,
    output lab_t        lab
);

    localparam int LMS_SW = 36;
    localparam int LABS_W = 38;
    localparam int T2_W   = 2 * LIN_W;
    localparam int T3_W   = 3 * LIN_W + 2;

    logic        [LIN_W-1:0]  lin_reg     [3];
    logic signed [LMS_SW-1:0] lms_sum_reg [3];
    logic        [LIN_W-1:0]  cv_reg      [CR_BITS][3];
    logic        [LIN_W-1:0]  cr_reg      [CR_BITS+1][3];
    logic        [T2_W-1:0]   cr2_reg     [CR_BITS][3];
    logic        [3*LIN_W-1:0] cr3_reg    [CR_BITS][3];
    logic signed [LABS_W-1:0] lab_sum_reg [3];
    lab_t                     lab_reg;

    logic signed [LMS_SW-1:0] lms_rnd [3];
    logic        [LIN_W-1:0]  lms_clp [3];

    // decode and LMS matrix
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lin_reg[k] <= DEC_LUT[color[8*k +: 8]];
                lms_sum_reg[k] <=
                    LMS_SW'(M_LMS[3*k])   * $signed(LMS_SW'(lin_reg[0])) +
                    LMS_SW'(M_LMS[3*k+1]) * $signed(LMS_SW'(lin_reg[1])) +
                    LMS_SW'(M_LMS[3*k+2]) * $signed(LMS_SW'(lin_reg[2]));
            end
        end
    end

    // round and clamp to 0..1
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lms_rnd[k] = (lms_sum_reg[k] + LMS_SW'(32768)) >>> 16;
            if (lms_rnd[k] < 0)
                lms_clp[k] = '0;
            else if (lms_rnd[k] > LMS_SW'(ONE16))
                lms_clp[k] = LIN_W'(ONE16);
            else
                lms_clp[k] = LIN_W'(lms_rnd[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cv_reg[0][k]  <= lms_clp[k];
                cr_reg[0][k]  <= '0;
                cr2_reg[0][k] <= '0;
                cr3_reg[0][k] <= '0;
            end
        end
    end

    // cube root of v * 2^32, one result bit per stage
    for (genvar s = 0; s < CR_BITS; s++)
    begin : g_cbrt
        localparam int B = CR_BITS - 1 - s;
        logic [T3_W-1:0] t3   [3];
        logic [T2_W-1:0] t2   [3];
        logic            take [3];

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                t3[k] = T3_W'(cr3_reg[s][k])
                      + ((T3_W'(cr2_reg[s][k]) * T3_W'(3)) << B)
                      + ((T3_W'(cr_reg[s][k]) * T3_W'(3)) << (2 * B))
                      + (T3_W'(1) << (3 * B));
                t2[k] = T2_W'(cr2_reg[s][k])
                      + (T2_W'(cr_reg[s][k]) << (B + 1))
                      + (T2_W'(1) << (2 * B));
                take[k] = (t3[k] <= T3_W'({cv_reg[s][k], 32'b0}));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cr_reg[s+1][k] <= take[k] ? (cr_reg[s][k] | (LIN_W'(1) << B))
                                              : cr_reg[s][k];
                end
            end
        end

        if (s < CR_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        cv_reg[s+1][k]  <= cv_reg[s][k];
                        cr2_reg[s+1][k] <= take[k] ? t2[k] : cr2_reg[s][k];
                        cr3_reg[s+1][k] <= take[k] ? (3*LIN_W)'(t3[k]) : cr3_reg[s][k];
                    end
                end
            end
        end
    end

    // Lab matrix, then round
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lab_sum_reg[k] <=
                    LABS_W'(M_LAB[3*k])   * $signed(LABS_W'(cr_reg[CR_BITS][0])) +
                    LABS_W'(M_LAB[3*k+1]) * $signed(LABS_W'(cr_reg[CR_BITS][1])) +
                    LABS_W'(M_LAB[3*k+2]) * $signed(LABS_W'(cr_reg[CR_BITS][2]));
            end
            lab_reg.l <= LAB_W'((lab_sum_reg[0] + LABS_W'(32768)) >>> 16);
            lab_reg.a <= LAB_W'((lab_sum_reg[1] + LABS_W'(32768)) >>> 16);
            lab_reg.b <= LAB_W'((lab_sum_reg[2] + LABS_W'(32768)) >>> 16);
        end
    end

    assign lab = lab_reg;

endmodule

// ----- rtl/core/okcn_encode.sv -----
// ============================================================================
// okcn_encode: linear Q16 to sRGB byte
// Binary search over the encode threshold table, one code bit per stage.
// ============================================================================
module okcn_encode
    import okcn_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [LIN_W-1:0]    x,
    output logic [ENC_BITS-1:0] code
);

    logic [LIN_W-1:0]    x_reg    [ENC_BITS-1];
    logic [ENC_BITS-1:0] code_reg [ENC_BITS];

    for (genvar s = 0; s < ENC_BITS; s++)
    begin : g_step
        localparam int B = ENC_BITS - 1 - s;
        logic [LIN_W-1:0]    xin;
        logic [ENC_BITS-1:0] cin;
        logic [ENC_BITS-1:0] cand;

        if (s == 0)
        begin : g_first
            assign xin = x;
            assign cin = '0;
        end
        else
        begin : g_next
            assign xin = x_reg[s-1];
            assign cin = code_reg[s-1];
        end

        assign cand = cin | (ENC_BITS'(1) << B);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                code_reg[s] <= (xin >= ENC_THR[cand]) ? cand : cin;
            end
        end

        if (s < ENC_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[s] <= xin;
                end
            end
        end
    end

    assign code = code_reg[ENC_BITS-1];

endmodule

// ----- rtl/core/oklab_contrast_nudge.sv -----
// ============================================================================
// oklab_contrast_nudge: keep a foreground color apart from a reference
// Fully pipelined Oklab distance check and lightness adjustment.
// ============================================================================
// Each transfer on the slave stream carries a foreground color and a
// reference color; each transfer on the master stream carries one result
// color, in order. A new pair is taken every clock cycle while the
// pipeline is not stalled. The depth of the pipeline comes from the
// bit-serial roots: 17 stages for the cube roots of the Oklab conversion,
// 17 for the square root of the lightness offset, and 8 for the binary
// search of the sRGB encode table, plus the matrix stages. When the master
// side holds tready low the whole pipeline holds; nothing is dropped. Write
// min_squared_distance (Q16) only while no pair is in flight. A zero
// minimum passes every color through unchanged.
module oklab_contrast_nudge
    import okcn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,   // min_squared_distance
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [55:0]      s_tdata,     // fore_color[31:0], reference_color[55:32]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata      // result_color[31:0]
);

    // stage numbers, counted in register edges after the input transfer
    localparam int S_SQR = LAB_LAT + 1;        // squared differences
    localparam int S_CMP = S_SQR + 1;          // compare, root argument
    localparam int S_RT  = S_CMP + SQ_BITS;    // square root done
    localparam int S_NL  = S_RT + 1;           // new lightness
    localparam int S_BS  = S_NL + 1;           // back matrix sums
    localparam int S_LP  = S_BS + 1;           // rounded LMS'
    localparam int S_SQ2 = S_LP + 1;           // squares
    localparam int S_CU  = S_SQ2 + 1;          // cubes
    localparam int S_RS  = S_CU + 1;           // RGB sums
    localparam int S_X   = S_RS + 1;           // clamped linear RGB
    localparam int S_ENC = S_X + ENC_BITS;     // encoded bytes
    localparam int TOTAL = S_ENC + 1;          // output register
    localparam int NPASS = S_ENC - S_CMP + 1;

    localparam int D_W   = LAB_W + 1;
    localparam int SQ_W  = 2 * D_W;
    localparam int DS_W  = SQ_W + 2;
    localparam int TH_W  = CFG_W + 16;
    localparam int R2_W  = 2 * SQ_BITS + 1;
    localparam int NL_W  = LAB_W + 2;
    localparam int BS_W  = 42;
    localparam int LP_W  = 22;
    localparam int P1_W  = 2 * LP_W;
    localparam int SQ2_W = 26;
    localparam int P2_W  = SQ2_W + LP_W;
    localparam int CU_W  = 26;
    localparam int RS_W  = 48;

    logic adv;
    logic [TOTAL-1:0] vld_reg;
    logic [CFG_W-1:0] min_reg;

    lab_t ref_lab;
    lab_t fore_lab;

    logic [31:0] fore_dly_reg [S_ENC];
    logic        pass_dly_reg [NPASS];

    // squared differences
    logic [SQ_W-1:0]         dl2_reg, da2_reg, db2_reg;
    logic signed [LAB_W-1:0] c_rl_reg, c_fl_reg, c_fa_reg, c_fb_reg;

    // square root pipeline
    logic [TH_W-1:0]         rt_v_reg   [SQ_BITS+1];
    logic [SQ_BITS-1:0]      rt_r_reg   [SQ_BITS+1];
    logic [R2_W-1:0]         rt_r2_reg  [SQ_BITS];
    logic signed [LAB_W-1:0] rt_rl_reg  [SQ_BITS+1];
    logic signed [LAB_W-1:0] rt_fa_reg  [SQ_BITS+1];
    logic signed [LAB_W-1:0] rt_fb_reg  [SQ_BITS+1];
    logic                    rt_blw_reg [SQ_BITS+1];

    // back conversion
    logic signed [NL_W-1:0]  nl_reg;
    logic signed [LAB_W-1:0] n_fa_reg, n_fb_reg;
    logic signed [BS_W-1:0]  bsum_reg [3];
    logic signed [LP_W-1:0]  lp_reg   [3];
    logic signed [LP_W-1:0]  lpd_reg  [3];
    logic signed [SQ2_W-1:0] sq_reg   [3];
    logic signed [CU_W-1:0]  cu_reg   [3];
    logic signed [RS_W-1:0]  rsum_reg [3];
    logic [LIN_W-1:0]        x_reg    [3];
    logic [ENC_BITS-1:0]     code     [3];
    logic [31:0]             result_reg;

    // the whole pipeline advances together; hold everything on a stalled output
    assign adv      = !vld_reg[TOTAL-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[TOTAL-1];
    assign m_tdata  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            min_reg <= '0;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[TOTAL-2:0], s_tvalid && adv};
            if (cfg_we)
                min_reg <= cfg_wdata;
        end
    end

    // both colors to Oklab in parallel
    okcn_to_lab u_ref_lab
    (
        .clk   (clk),
        .en    (adv),
        .color (s_tdata[55:32]),
        .lab   (ref_lab)
    );

    okcn_to_lab u_fore_lab
    (
        .clk   (clk),
        .en    (adv),
        .color (s_tdata[23:0]),
        .lab   (fore_lab)
    );

    // carry the original foreground to the output stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fore_dly_reg[0] <= s_tdata[31:0];
            for (int i = 1; i < S_ENC; i++)
                fore_dly_reg[i] <= fore_dly_reg[i-1];
        end
    end

    // differences and their squares
    logic signed [D_W-1:0] dl, da, db;
    assign dl = D_W'(ref_lab.l) - D_W'(fore_lab.l);
    assign da = D_W'(ref_lab.a) - D_W'(fore_lab.a);
    assign db = D_W'(ref_lab.b) - D_W'(fore_lab.b);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl2_reg  <= SQ_W'(SQ_W'(dl) * SQ_W'(dl));
            da2_reg  <= SQ_W'(SQ_W'(da) * SQ_W'(da));
            db2_reg  <= SQ_W'(SQ_W'(db) * SQ_W'(db));
            c_rl_reg <= ref_lab.l;
            c_fl_reg <= fore_lab.l;
            c_fa_reg <= fore_lab.a;
            c_fb_reg <= fore_lab.b;
        end
    end

    // distance check and square root argument
    logic [DS_W-1:0] dist_sum, ab2, thr;
    assign dist_sum = DS_W'(dl2_reg) + DS_W'(da2_reg) + DS_W'(db2_reg);
    assign ab2      = DS_W'(da2_reg) + DS_W'(db2_reg);
    assign thr      = DS_W'({min_reg, 16'b0});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pass_dly_reg[0] <= (dist_sum >= thr);
            rt_v_reg[0]     <= (ab2 >= thr) ? '0 : TH_W'(thr - ab2);
            rt_r_reg[0]     <= '0;
            rt_r2_reg[0]    <= '0;
            rt_rl_reg[0]    <= c_rl_reg;
            rt_fa_reg[0]    <= c_fa_reg;
            rt_fb_reg[0]    <= c_fb_reg;
            rt_blw_reg[0]   <= (c_fl_reg < c_rl_reg);
            for (int i = 1; i < NPASS; i++)
                pass_dly_reg[i] <= pass_dly_reg[i-1];
        end
    end

    // floor square root, one result bit per stage
    for (genvar s = 0; s < SQ_BITS; s++)
    begin : g_sqrt
        localparam int B = SQ_BITS - 1 - s;
        logic [R2_W-1:0] t2;
        logic            take;

        assign t2 = rt_r2_reg[s]
                  + (R2_W'(rt_r_reg[s]) << (B + 1))
                  + (R2_W'(1) << (2 * B));
        assign take = (t2 <= R2_W'(rt_v_reg[s]));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_r_reg[s+1]   <= take ? (rt_r_reg[s] | (SQ_BITS'(1) << B)) : rt_r_reg[s];
                rt_v_reg[s+1]   <= rt_v_reg[s];
                rt_rl_reg[s+1]  <= rt_rl_reg[s];
                rt_fa_reg[s+1]  <= rt_fa_reg[s];
                rt_fb_reg[s+1]  <= rt_fb_reg[s];
                rt_blw_reg[s+1] <= rt_blw_reg[s];
            end
        end

        if (s < SQ_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rt_r2_reg[s+1] <= take ? t2 : rt_r2_reg[s];
                end
            end
        end
    end

    // new lightness: stay on the foreground's side, else flip
    logic signed [NL_W-1:0] dsg, nl_try, nl_alt;
    assign dsg    = rt_blw_reg[SQ_BITS] ? -NL_W'(rt_r_reg[SQ_BITS])
                                        : NL_W'(rt_r_reg[SQ_BITS]);
    assign nl_try = NL_W'(rt_rl_reg[SQ_BITS]) + dsg;
    assign nl_alt = NL_W'(rt_rl_reg[SQ_BITS]) - dsg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nl_reg   <= (nl_try < 0 || nl_try > NL_W'(ONE16)) ? nl_alt : nl_try;
            n_fa_reg <= rt_fa_reg[SQ_BITS];
            n_fb_reg <= rt_fb_reg[SQ_BITS];
        end
    end

    // back to LMS', cube, RGB matrix
    logic signed [P1_W-1:0] p1 [3];
    logic signed [P2_W-1:0] p2 [3];
    logic signed [RS_W-1:0] rrnd [3];
    logic [LIN_W-1:0]       xclp [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p1[k] = P1_W'(lp_reg[k]) * P1_W'(lp_reg[k]);
            p2[k] = P2_W'(sq_reg[k]) * P2_W'(lpd_reg[k]);
            rrnd[k] = (rsum_reg[k] + RS_W'(32768)) >>> 16;
            if (rrnd[k] < 0)
                xclp[k] = '0;
            else if (rrnd[k] > RS_W'(ONE16))
                xclp[k] = LIN_W'(ONE16);
            else
                xclp[k] = LIN_W'(rrnd[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                bsum_reg[k] <= BS_W'(M_BACK[3*k])   * BS_W'(nl_reg)
                             + BS_W'(M_BACK[3*k+1]) * BS_W'(n_fa_reg)
                             + BS_W'(M_BACK[3*k+2]) * BS_W'(n_fb_reg);
                lp_reg[k]   <= LP_W'((bsum_reg[k] + BS_W'(32768)) >>> 16);
                lpd_reg[k]  <= lp_reg[k];
                sq_reg[k]   <= SQ2_W'((p1[k] + P1_W'(32768)) >>> 16);
                cu_reg[k]   <= CU_W'((p2[k] + P2_W'(32768)) >>> 16);
                rsum_reg[k] <= RS_W'(M_RGB[3*k])   * RS_W'(cu_reg[0])
                             + RS_W'(M_RGB[3*k+1]) * RS_W'(cu_reg[1])
                             + RS_W'(M_RGB[3*k+2]) * RS_W'(cu_reg[2]);
                x_reg[k]    <= xclp[k];
            end
        end
    end

    // gamma encode, one encoder per channel
    for (genvar k = 0; k < 3; k++)
    begin : g_enc
        okcn_encode u_encode
        (
            .clk  (clk),
            .en   (adv),
            .x    (x_reg[k]),
            .code (code[k])
        );
    end

    // pick the unchanged or the adjusted color; keep the top byte
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= pass_dly_reg[NPASS-1] ? fore_dly_reg[S_ENC-1]
                        : {fore_dly_reg[S_ENC-1][31:24], code[2], code[1], code[0]};
        end
    end

    // a stalled pipeline keeps its occupancy
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    // the square root result is the floor root of its argument
    a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_RT-1] |->
            (R2_W'(rt_r_reg[SQ_BITS]) * R2_W'(rt_r_reg[SQ_BITS])
                <= R2_W'(rt_v_reg[SQ_BITS]))
            && ((R2_W'(rt_r_reg[SQ_BITS]) + R2_W'(1)) * (R2_W'(rt_r_reg[SQ_BITS]) + R2_W'(1))
                > R2_W'(rt_v_reg[SQ_BITS])))
        else $error("square root is not the floor root");

    // linear RGB entering the encoders stays within 0..1
    a_x_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_X-1] |-> (x_reg[0] <= LIN_W'(ONE16)) && (x_reg[1] <= LIN_W'(ONE16))
                           && (x_reg[2] <= LIN_W'(ONE16)))
        else $error("linear RGB out of range at the encoders");

endmodule
